[rtl/ir_pulse_width_frame_decoder_assert.svh]
// Assertion macros used by the checker file.
`ifndef IR_PULSE_WIDTH_FRAME_DECODER_ASSERT_SVH
`define IR_PULSE_WIDTH_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IRPWD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irpwd assertion failed");

// Next-cycle implication, disabled during reset.
`define IRPWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irpwd assertion failed");

`endif

[rtl/irpwd_pkg.sv]
package irpwd_pkg;

  localparam int unsigned TS_W    = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned CIDX_W  = 3;

  // Request kinds
  localparam logic ACT_EDGE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_START_WIDTH_MIN = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_START_WIDTH_MAX = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_BIT_WIDTH_MIN   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_BIT_WIDTH_MAX   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_BIT_THRESHOLD   = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_FRAME_TIMEOUT   = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_RELEASE_TIMEOUT = 3'd6;

  // Reset values (Sony timing)
  localparam logic [CFG_W-1:0] RST_START_WIDTH_MIN = 16'd28;
  localparam logic [CFG_W-1:0] RST_START_WIDTH_MAX = 16'd46;
  localparam logic [CFG_W-1:0] RST_BIT_WIDTH_MIN   = 16'd7;
  localparam logic [CFG_W-1:0] RST_BIT_WIDTH_MAX   = 16'd23;
  localparam logic [CFG_W-1:0] RST_BIT_THRESHOLD   = 16'd14;
  localparam logic [CFG_W-1:0] RST_FRAME_TIMEOUT   = 16'd675;
  localparam logic [CFG_W-1:0] RST_RELEASE_TIMEOUT = 16'd937;

  typedef struct packed {
    logic [CFG_W-1:0] start_width_min;
    logic [CFG_W-1:0] start_width_max;
    logic [CFG_W-1:0] bit_width_min;
    logic [CFG_W-1:0] bit_width_max;
    logic [CFG_W-1:0] bit_threshold;
    logic [CFG_W-1:0] frame_timeout;
    logic [CFG_W-1:0] release_timeout;
  } irpwd_cfg_t;

  typedef struct packed {
    logic              action;
    logic [TS_W-1:0]   timestamp;
    logic              rising;
  } irpwd_req_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              code_present;
    logic              frame_done;
  } irpwd_res_t;

endpackage

[rtl/irpwd_if.sv]
interface irpwd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [irpwd_pkg::TS_W-1:0]    timestamp;
  logic                          rising;

  modport source (output valid, output action, output timestamp, output rising,
                  input ready);
  modport sink   (input valid, input action, input timestamp, input rising,
                  output ready);
endinterface

interface irpwd_out_if;
  logic                          valid;
  logic                          ready;
  logic [irpwd_pkg::CODE_W-1:0]  code;
  logic                          code_present;
  logic                          frame_done;

  modport source (output valid, output code, output code_present, output frame_done,
                  input ready);
  modport sink   (input valid, input code, input code_present, input frame_done,
                  output ready);
endinterface

[rtl/irpwd_core.sv]
module irpwd_core #(
  parameter int unsigned FRAME_BITS_A = 12,
  parameter int unsigned FRAME_BITS_B = 15,
  parameter int unsigned FRAME_BITS_C = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  irpwd_pkg::irpwd_req_t req,
  input  irpwd_pkg::irpwd_cfg_t cfg,
  output irpwd_pkg::irpwd_res_t res
);
  import irpwd_pkg::*;

  logic [TS_W-1:0]   prev_edge_r, prev_edge_nxt;
  logic [CODE_W-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TS_W-1:0]   deadline_r, deadline_nxt;
  logic              armed_r, armed_nxt;
  logic [CODE_W-1:0] held_code_r, held_code_nxt;
  logic              held_valid_r, held_valid_nxt;
  logic              done;

  logic [TS_W-1:0]   width;
  logic              in_start;
  logic              in_bit;
  logic              hit;
  logic              len_ok;

  assign width    = req.timestamp - prev_edge_r;
  assign in_start = (cfg.start_width_min < width) && (width < cfg.start_width_max);
  assign in_bit   = (cfg.bit_width_min < width) && (width < cfg.bit_width_max);
  assign hit      = armed_r && (req.timestamp == deadline_r);
  assign len_ok   = (cnt_r == CNT_W'(FRAME_BITS_A)) || (cnt_r == CNT_W'(FRAME_BITS_B)) ||
                    (cnt_r == CNT_W'(FRAME_BITS_C));

  always_comb begin
    prev_edge_nxt  = prev_edge_r;
    shift_nxt      = shift_r;
    cnt_nxt        = cnt_r;
    deadline_nxt   = deadline_r;
    armed_nxt      = armed_r;
    held_code_nxt  = held_code_r;
    held_valid_nxt = held_valid_r;
    done           = 1'b0;
    if (req.action == ACT_EDGE) begin
      prev_edge_nxt = req.timestamp;
      if (req.rising) begin
        // start window wins when both windows match
        priority if (in_start) begin
          deadline_nxt = req.timestamp + cfg.frame_timeout;
          armed_nxt    = 1'b1;
          cnt_nxt      = '0;
          shift_nxt    = CODE_W'(1);
        end else if (in_bit) begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          shift_nxt = {shift_r[CODE_W-2:0], (width < cfg.bit_threshold)};
        end else begin
          cnt_nxt = '0;
        end
      end
    end else if (hit) begin
      if (len_ok) begin
        held_code_nxt  = shift_r;
        held_valid_nxt = 1'b1;
        deadline_nxt   = deadline_r + cfg.release_timeout;
        done           = 1'b1;
      end else begin
        held_code_nxt  = '0;
        held_valid_nxt = 1'b0;
        armed_nxt      = 1'b0;
      end
      cnt_nxt   = '0;
      shift_nxt = '0;
    end
  end

  always_comb begin
    res.code         = held_code_nxt;
    res.code_present = held_valid_nxt;
    res.frame_done   = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_edge_r  <= '0;
      shift_r      <= '0;
      cnt_r        <= '0;
      deadline_r   <= '0;
      armed_r      <= 1'b0;
      held_code_r  <= '0;
      held_valid_r <= 1'b0;
    end else if (step) begin
      prev_edge_r  <= prev_edge_nxt;
      shift_r      <= shift_nxt;
      cnt_r        <= cnt_nxt;
      deadline_r   <= deadline_nxt;
      armed_r      <= armed_nxt;
      held_code_r  <= held_code_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

endmodule

[rtl/ir_pulse_width_frame_decoder.sv]
// IR pulse-width frame decoder (Sony timing by default).
// in_req carries one request per edge or timer tick: action (0 edge, 1 tick),
// the 16-bit timer value and the edge polarity. Rising edges are measured
// against the previous edge; start and bit widths build a frame, and a tick
// at the armed deadline judges it.
// out_res returns exactly one result per request: the held code, whether a
// code is held, and whether this tick completed a frame.
// cfg_we/cfg_index/cfg_wdata write the seven 16-bit timing registers; write
// them only while no request is in flight.
// Decoder state and the result register update when a request is accepted.
// Throughput: one request per cycle while in_req.ready is high.
// A two-entry output buffer (output register plus skid register) lets one
// more request in while a result waits; in_req.ready drops only when both
// entries are full, and results leave in order as out_res.ready allows.
// Reset (synchronous rst_n low) clears the decoder state and output buffer
// and loads the default timing registers.
module ir_pulse_width_frame_decoder #(
  parameter int unsigned FRAME_BITS_A = 12,
  parameter int unsigned FRAME_BITS_B = 15,
  parameter int unsigned FRAME_BITS_C = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  irpwd_in_if.sink                        in_req,
  irpwd_out_if.source                     out_res,
  input  logic                            cfg_we,
  input  logic [irpwd_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [irpwd_pkg::CFG_W-1:0]     cfg_wdata
);
  import irpwd_pkg::*;

  irpwd_cfg_t cfg_r;
  irpwd_req_t req;
  irpwd_res_t res;
  irpwd_res_t main_r, skid_r;
  logic       main_vld_r, skid_vld_r;
  logic       acc, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_width_min <= RST_START_WIDTH_MIN;
      cfg_r.start_width_max <= RST_START_WIDTH_MAX;
      cfg_r.bit_width_min   <= RST_BIT_WIDTH_MIN;
      cfg_r.bit_width_max   <= RST_BIT_WIDTH_MAX;
      cfg_r.bit_threshold   <= RST_BIT_THRESHOLD;
      cfg_r.frame_timeout   <= RST_FRAME_TIMEOUT;
      cfg_r.release_timeout <= RST_RELEASE_TIMEOUT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_WIDTH_MIN: cfg_r.start_width_min <= cfg_wdata;
        CFG_START_WIDTH_MAX: cfg_r.start_width_max <= cfg_wdata;
        CFG_BIT_WIDTH_MIN:   cfg_r.bit_width_min   <= cfg_wdata;
        CFG_BIT_WIDTH_MAX:   cfg_r.bit_width_max   <= cfg_wdata;
        CFG_BIT_THRESHOLD:   cfg_r.bit_threshold   <= cfg_wdata;
        CFG_FRAME_TIMEOUT:   cfg_r.frame_timeout   <= cfg_wdata;
        CFG_RELEASE_TIMEOUT: cfg_r.release_timeout <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign req.action    = in_req.action;
  assign req.timestamp = in_req.timestamp;
  assign req.rising    = in_req.rising;

  assign in_req.ready = !skid_vld_r;
  assign acc          = in_req.valid && !skid_vld_r;
  assign pop          = main_vld_r && out_res.ready;

  irpwd_core #(
    .FRAME_BITS_A (FRAME_BITS_A),
    .FRAME_BITS_B (FRAME_BITS_B),
    .FRAME_BITS_C (FRAME_BITS_C)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (acc),
    .req   (req),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Output register with skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_vld_r) begin
          main_vld_r <= 1'b1;
          skid_vld_r <= 1'b0;
        end else begin
          main_vld_r <= acc;
        end
      end else if (acc) begin
        if (main_vld_r) begin
          skid_vld_r <= 1'b1;
        end else begin
          main_vld_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_vld_r) begin
      main_r <= skid_r;
    end else if (acc && (pop || !main_vld_r)) begin
      main_r <= res;
    end
    if (acc && main_vld_r && !pop) begin
      skid_r <= res;
    end
  end

  assign out_res.valid        = main_vld_r;
  assign out_res.code         = main_r.code;
  assign out_res.code_present = main_r.code_present;
  assign out_res.frame_done   = main_r.frame_done;

endmodule

[rtl/irpwd_checker.sv]
`include "ir_pulse_width_frame_decoder_assert.svh"

module irpwd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [irpwd_pkg::CODE_W-1:0]   out_code,
  input logic                           out_code_present,
  input logic                           out_frame_done
);

  // A stalled result holds its payload
  `IRPWD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_code) && $stable(out_code_present) && $stable(out_frame_done))

  // Without a held code the code reads as zero
  `IRPWD_ASSERT_NOW(a_code_zero, clk, rst_n, out_valid && !out_code_present, out_code == '0)

  // A completed frame always leaves a code held
  `IRPWD_ASSERT_NOW(a_done_present, clk, rst_n, out_valid && out_frame_done, out_code_present)

endmodule

bind ir_pulse_width_frame_decoder irpwd_checker u_irpwd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_res.valid),
  .out_ready        (out_res.ready),
  .out_code         (out_res.code),
  .out_code_present (out_res.code_present),
  .out_frame_done   (out_res.frame_done)
);
